[design/timed_reservation_table_unit_macros.svh]
// Assertion macros for the reservation table block.
`ifndef TIMED_RESERVATION_TABLE_UNIT_MACROS_SVH
`define TIMED_RESERVATION_TABLE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("implication check failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_IMPL(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)

`endif

`endif

[design/trt_pkg.sv]
package trt_pkg;

    localparam int NODE_ID_BITS = 16;
    localparam int TIME_BITS    = 32;

    localparam logic [2:0] FUNC_ADD    = 3'd0;
    localparam logic [2:0] FUNC_REMOVE = 3'd1;
    localparam logic [2:0] FUNC_QUERY  = 3'd2;
    localparam logic [2:0] FUNC_EXPIRE = 3'd3;
    localparam logic [2:0] FUNC_CLEAR  = 3'd4;

    typedef struct packed {
        logic [2:0]              func;
        logic [NODE_ID_BITS-1:0] node_id;
        logic [TIME_BITS-1:0]    expiry_time;
        logic [TIME_BITS-1:0]    now_time;
    } t_in_item;

    typedef struct packed {
        logic blocked;
        logic changed;
        logic table_full;
        logic stale_add;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_last;
    } t_status;

endpackage

[design/trt_ctrl.sv]
module trt_ctrl
    import trt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    busy
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;

    always_comb begin
        n_state = r_state;
        n_busy  = r_busy;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                    n_busy     = 1'b1;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_IDLE;
                n_busy       = 1'b0;
            end
            default: begin
                n_state = ST_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign busy = r_busy;

endmodule

[design/trt_dp.sv]
module trt_dp
    import trt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  t_cmd      i_cmd,
    output t_status   o_status,
    output t_out_item o_result,
    output logic      o_res_valid
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    t_in_item                r_item;
    logic [IDX_W-1:0]        r_idx;
    logic                    r_found;
    logic                    r_free_ok;
    logic [IDX_W-1:0]        r_free_idx;
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic                    r_mark;
    t_out_item               r_res;
    t_out_item               n_res;
    logic                    r_res_vld;

    logic [NODE_ID_BITS-1:0] r_node   [TABLE_ENTRIES];
    logic [TIME_BITS-1:0]    r_expiry [TABLE_ENTRIES];

    logic [NODE_ID_BITS-1:0] w_cur_node;
    logic [TIME_BITS-1:0]    w_cur_expiry;
    logic                    w_cur_valid;
    logic                    w_hit;
    logic                    w_do_insert;

    assign w_cur_node   = r_node[r_idx];
    assign w_cur_expiry = r_expiry[r_idx];
    assign w_cur_valid  = r_valid[r_idx];
    assign w_hit        = w_cur_valid && (w_cur_node == r_item.node_id);
    assign w_do_insert  = i_cmd.finish && (r_item.func == FUNC_ADD) && !r_found && r_free_ok;

    assign o_status.scan_last = (r_idx == LAST_IDX);

    always_comb begin
        n_res = '0;
        case (r_item.func)
            FUNC_ADD: begin
                n_res.stale_add  = (r_item.expiry_time < r_item.now_time);
                n_res.table_full = !r_found && !r_free_ok;
            end
            FUNC_QUERY:  n_res.blocked = r_found;
            FUNC_EXPIRE: n_res.changed = r_mark;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.finish) begin
            r_res <= n_res;
        end
    end

    // Control flags and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_found    <= 1'b0;
            r_free_ok  <= 1'b0;
            r_free_idx <= '0;
            r_valid    <= '0;
            r_mark     <= 1'b0;
            r_res_vld  <= 1'b0;
        end else begin
            r_res_vld <= i_cmd.finish;
            if (i_cmd.load) begin
                r_idx     <= '0;
                r_found   <= 1'b0;
                r_free_ok <= 1'b0;
            end
            if (i_cmd.scan) begin
                r_idx <= r_idx + 1'b1;
                if (w_hit) begin
                    r_found <= 1'b1;
                end
                if (!w_cur_valid && !r_free_ok) begin
                    r_free_ok  <= 1'b1;
                    r_free_idx <= r_idx;
                end
                case (r_item.func)
                    FUNC_REMOVE: begin
                        if (w_hit && !r_found) begin
                            r_valid[r_idx] <= 1'b0;
                            r_mark         <= 1'b1;
                        end
                    end
                    FUNC_EXPIRE: begin
                        // expiry equal to now survives
                        if (w_cur_valid && (r_item.now_time > w_cur_expiry)) begin
                            r_valid[r_idx] <= 1'b0;
                            r_mark         <= 1'b1;
                        end
                    end
                    FUNC_CLEAR: begin
                        if (w_cur_valid) begin
                            r_valid[r_idx] <= 1'b0;
                            r_mark         <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.finish && (r_item.func == FUNC_EXPIRE)) begin
                r_mark <= 1'b0;
            end
            if (w_do_insert) begin
                r_valid[r_free_idx] <= 1'b1;
                r_mark              <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_insert) begin
            r_node[r_free_idx]   <= r_item.node_id;
            r_expiry[r_free_idx] <= r_item.expiry_time;
        end
    end

    assign o_result    = r_res;
    assign o_res_valid = r_res_vld;

endmodule

[design/timed_reservation_table_unit.sv]
// Timed reservation table: up to TABLE_ENTRIES node ids, each with an expiry tick.
// Input channel: present i_item and raise start; the item is taken at a rising
// edge with start high and busy low. func selects add, remove, query, expire or
// clear; unused codes return an all-zero result.
// Result channel: one result per item, on o_result while o_res_valid is high
// for a single cycle. The receiver has no way to stall; it must take it then.
// Timing: every item walks the table one entry per cycle. The result strobe
// rises in the same cycle as busy drops, and a new item is taken only after
// that, so the block takes no new item while one is in flight. The
// entry-by-entry scan sets how often items can be taken.
// Reset (synchronous, active low) empties the table, clears the change mark
// and drops busy and the strobe. Entry ids and times are not cleared; they are
// only read behind their valid bits.
module timed_reservation_table_unit
    import trt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_item,
    output logic      busy,
    output t_out_item o_result,
    output logic      o_res_valid
);

`include "timed_reservation_table_unit_macros.svh"

    t_cmd    w_cmd;
    t_status w_status;

    trt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .busy     (busy)
    );

    trt_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_result    (o_result),
        .o_res_valid (o_res_valid)
    );

    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `ASSERT_IMPL(a_result_idle, i_clk, i_rst_n, o_res_valid, !busy)
    `ASSERT_NEXT(a_finish_result, i_clk, i_rst_n, w_cmd.finish, o_res_valid && !busy)
    `ASSERT_NEXT(a_last_finish, i_clk, i_rst_n, w_cmd.scan && w_status.scan_last, w_cmd.finish)

endmodule

[tb/tb_timed_reservation_table_unit.sv]
`timescale 1ns / 1ps

module tb_timed_reservation_table_unit;
    import trt_pkg::*;

    localparam int TABLE_SLOTS   = 16;
    localparam int RANDOM_ITEMS  = 1950;
    localparam int ID_POOL_SIZE  = 24;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = TABLE_SLOTS + 4;
    localparam int MAX_PRINTED   = 40;

    // codes the block has no operation for
    localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
    localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;

    class reservation_scoreboard;
        bit                    slot_used[TABLE_SLOTS];
        bit [NODE_ID_BITS-1:0] slot_id[TABLE_SLOTS];
        bit [TIME_BITS-1:0]    slot_expiry[TABLE_SLOTS];
        bit                    change_mark;
        t_out_item             pending_flags[$];
        int unsigned           mismatches;

        function int find_id(logic [NODE_ID_BITS-1:0] id);
            for (int i = 0; i < TABLE_SLOTS; i++)
                if (slot_used[i] && slot_id[i] == id)
                    return i;
            return -1;
        endfunction

        function int find_free();
            for (int i = 0; i < TABLE_SLOTS; i++)
                if (!slot_used[i])
                    return i;
            return -1;
        endfunction

        function int pending();
            return pending_flags.size();
        endfunction

        // Applies one accepted item to the table copy and queues its flags.
        function void note_item(t_in_item it);
            t_out_item want;
            int        slot;
            want = '0;
            case (it.func)
                FUNC_ADD: begin
                    want.stale_add = (it.expiry_time < it.now_time);
                    if (find_id(it.node_id) < 0) begin
                        slot = find_free();
                        if (slot < 0) begin
                            want.table_full = 1'b1;
                        end else begin
                            slot_used[slot]   = 1'b1;
                            slot_id[slot]     = it.node_id;
                            slot_expiry[slot] = it.expiry_time;
                            change_mark       = 1'b1;
                        end
                    end
                end
                FUNC_REMOVE: begin
                    slot = find_id(it.node_id);
                    if (slot >= 0) begin
                        slot_used[slot] = 1'b0;
                        change_mark     = 1'b1;
                    end
                end
                FUNC_QUERY: begin
                    want.blocked = (find_id(it.node_id) >= 0);
                end
                FUNC_EXPIRE: begin
                    // an entry whose expiry equals now survives
                    for (int i = 0; i < TABLE_SLOTS; i++) begin
                        if (slot_used[i] && it.now_time > slot_expiry[i]) begin
                            slot_used[i] = 1'b0;
                            change_mark  = 1'b1;
                        end
                    end
                    want.changed = change_mark;
                    change_mark  = 1'b0;
                end
                FUNC_CLEAR: begin
                    for (int i = 0; i < TABLE_SLOTS; i++) begin
                        if (slot_used[i]) begin
                            slot_used[i] = 1'b0;
                            change_mark  = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
            pending_flags = {pending_flags, want};
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= MAX_PRINTED)
                $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task compare_flag(string field, logic got, logic want);
            if (got !== want)
                report($sformatf("%s got %b expected %b", field, got, want));
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (pending_flags.size() == 0) begin
                report($sformatf("result %b with no item outstanding", got));
                return;
            end
            want = pending_flags.pop_front();
            compare_flag("blocked", got.blocked, want.blocked);
            compare_flag("changed", got.changed, want.changed);
            compare_flag("table_full", got.table_full, want.table_full);
            compare_flag("stale_add", got.stale_add, want.stale_add);
        endtask
    endclass

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_in_item  i_item  = '0;
    logic      busy;
    t_out_item o_result;
    logic      o_res_valid;

    int unsigned           cycle_count = 0;
    bit [TIME_BITS-1:0]    sim_now;
    bit [NODE_ID_BITS-1:0] id_pool[ID_POOL_SIZE];

    reservation_scoreboard table_model = new();

    timed_reservation_table_unit #(
        .TABLE_ENTRIES(TABLE_SLOTS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_item     (i_item),
        .busy       (busy),
        .o_result   (o_result),
        .o_res_valid(o_res_valid)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result of the previous item is checked before a new item is noted
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_res_valid)
                table_model.check_result(o_result);
            if (start && !busy)
                table_model.note_item(i_item);
        end
    end

    task automatic send_item(t_in_item it);
        i_item <= it;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic send_op(logic [2:0] f, logic [NODE_ID_BITS-1:0] id,
                           logic [TIME_BITS-1:0] expiry, logic [TIME_BITS-1:0] now);
        t_in_item it;
        it.func        = f;
        it.node_id     = id;
        it.expiry_time = expiry;
        it.now_time    = now;
        send_item(it);
    endtask

    task automatic idle_for(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (table_model.pending() != 0);
    endtask

    // Mostly ids from a small pool so the table fills, hits and misses;
    // times follow a slowly advancing tick with occasional jumps.
    function automatic t_in_item random_item();
        t_in_item it;
        int       r;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 99) == 0)
            sim_now = $urandom;
        else
            sim_now = sim_now + $urandom_range(0, 20);
        it.now_time    = sim_now;
        it.expiry_time = $urandom;
        if ($urandom_range(0, 9) == 0)
            it.node_id = NODE_ID_BITS'($urandom_range(0, 65535));
        else
            it.node_id = id_pool[$urandom_range(0, ID_POOL_SIZE - 1)];
        if (r < 38) begin
            it.func = FUNC_ADD;
            case ($urandom_range(0, 19))
                0, 1, 2: it.expiry_time = sim_now - $urandom_range(1, 50);
                3:       it.expiry_time = $urandom;
                4:       it.expiry_time = sim_now;
                default: it.expiry_time = sim_now + $urandom_range(0, 200);
            endcase
        end else if (r < 53) begin
            it.func = FUNC_REMOVE;
        end else if (r < 73) begin
            it.func = FUNC_QUERY;
        end else if (r < 85) begin
            it.func = FUNC_EXPIRE;
        end else if (r < 89) begin
            it.func = FUNC_CLEAR;
        end else if (r < 94) begin
            it.func = 3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
        end else begin
            it.func     = 3'($urandom_range(0, FUNC_SPARE_LAST));
            it.node_id  = NODE_ID_BITS'($urandom_range(0, 65535));
            it.now_time = $urandom;
        end
        return it;
    endfunction

    initial begin
        int       burst_left;
        int       real_items;
        t_in_item it;

        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int i = 2; i < ID_POOL_SIZE; i++)
            id_pool[i] = NODE_ID_BITS'($urandom_range(0, 65535));
        sim_now = $urandom_range(0, 1000);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table: expire reports no change, clear leaves mark alone
        send_op(FUNC_EXPIRE, 16'h0000, 32'h0, 32'h0);
        send_op(FUNC_CLEAR, 16'hffff, 32'hffff_ffff, 32'hffff_ffff);
        send_op(FUNC_ADD, 16'h0000, 32'hffff_ffff, 32'h0);
        // stale add still goes in
        send_op(FUNC_ADD, 16'hffff, 32'h0, 32'hffff_ffff);
        // duplicate that is also stale
        send_op(FUNC_ADD, 16'h0000, 32'h0, 32'h1);
        send_op(FUNC_EXPIRE, 16'h0000, 32'h0, 32'd5);
        send_op(FUNC_QUERY, 16'hffff, 32'h0, 32'd5);
        send_op(FUNC_ADD, 16'h1234, 32'd100, 32'd50);
        // expiry equal to now survives
        send_op(FUNC_EXPIRE, 16'h0000, 32'h0, 32'd100);
        send_op(FUNC_EXPIRE, 16'h0000, 32'h0, 32'd100);
        send_op(FUNC_QUERY, 16'h1234, 32'h0, 32'd100);
        send_op(FUNC_REMOVE, 16'h5555, 32'h0, 32'd100);
        send_op(FUNC_REMOVE, 16'h1234, 32'h0, 32'd100);
        send_op(FUNC_SPARE_LAST, 16'h1234, 32'hffff_ffff, 32'h0);
        for (int k = 0; k < TABLE_SLOTS - 1; k++)
            send_op(FUNC_ADD, 16'h0001 << k, 32'd1000 + k, 32'd500);
        // table full, and stale on top
        send_op(FUNC_ADD, 16'h8000, 32'd10, 32'd20);
        send_op(FUNC_CLEAR, 16'h0000, 32'h0, 32'h0);

        drain_results();

        burst_left = 0;
        real_items = 0;
        while (real_items < RANDOM_ITEMS) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                if ($urandom_range(0, 19) == 0)
                    drain_results();
                else if ($urandom_range(0, 2) != 0)
                    idle_for($urandom_range(1, 40));
            end
            it = random_item();
            if (it.func <= FUNC_CLEAR)
                real_items++;
            send_item(it);
            burst_left--;
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (table_model.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/trt_pkg.sv
design/trt_ctrl.sv
design/trt_dp.sv
design/timed_reservation_table_unit.sv
tb/tb_timed_reservation_table_unit.sv
